[design/crlfrx_pkg.sv]
// Shared types and constants for the CR LF frame receiver.
`timescale 1ns / 1ps

package crlfrx_pkg;

	localparam int COUNT_W = 6;
	localparam int INDEX_W = 5;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_POLL = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [7:0] CODE_CR = 8'h0d;
	localparam logic [7:0] CODE_LF = 8'h0a;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         rx_byte;
		logic [INDEX_W-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic               frame_complete;
		logic [COUNT_W-1:0] frame_length;
		logic [7:0]         read_data;
	} out_item_t;

	typedef struct packed {
		logic               en;
		logic [COUNT_W-1:0] addr;
		logic [7:0]         data;
	} wr_req_t;

endpackage

[design/crlfrx_ctrl.sv]
// Frame state tracking: CR LF detection, start byte check, overflow and poll clear.
`timescale 1ns / 1ps

module crlfrx_ctrl #(
	parameter int CAPACITY = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  crlfrx_pkg::in_item_t        item,
	input  logic [7:0]                  start_byte,
	output crlfrx_pkg::wr_req_t         wr,
	output logic                        done,
	output logic [crlfrx_pkg::COUNT_W-1:0] count
);

	localparam logic [crlfrx_pkg::COUNT_W-1:0] CAP = crlfrx_pkg::COUNT_W'(CAPACITY);

	logic [crlfrx_pkg::COUNT_W-1:0] count_q, count_n;
	logic                           cr_q, cr_n;
	logic                           done_q, done_n;
	logic [7:0]                     first_q, first_n;
	logic [7:0]                     first_chk;

	always_comb begin
		count_n   = count_q;
		cr_n      = cr_q;
		done_n    = done_q;
		first_n   = first_q;
		first_chk = first_q;
		wr.en     = 1'b0;
		wr.addr   = count_q;
		wr.data   = item.rx_byte;
		if (fire) begin
			case (item.operation)
				crlfrx_pkg::OP_BYTE: begin
					if (!done_q) begin
						if (cr_q) begin
							if (item.rx_byte != crlfrx_pkg::CODE_LF) begin
								count_n = '0;
								cr_n    = 1'b0;
								done_n  = 1'b0;
							end else begin
								done_n = 1'b1;
							end
						end else if (item.rx_byte == crlfrx_pkg::CODE_CR) begin
							cr_n = 1'b1;
						end else if (count_q >= CAP) begin
							// overflow: drop the frame and discard this byte
							count_n = '0;
							cr_n    = 1'b0;
							done_n  = 1'b0;
						end else begin
							wr.en   = 1'b1;
							count_n = count_q + 1'b1;
							if (count_q == '0) begin
								first_n   = item.rx_byte;
								first_chk = item.rx_byte;
							end
							if (first_chk != start_byte) begin
								count_n = '0;
								cr_n    = 1'b0;
								done_n  = 1'b0;
							end
						end
					end
				end
				crlfrx_pkg::OP_POLL: begin
					if (done_q) begin
						count_n = '0;
						cr_n    = 1'b0;
						done_n  = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cr_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_n;
			cr_q    <= cr_n;
			done_q  <= done_n;
		end
	end

	// copy of store entry 0, valid whenever count_q is nonzero
	always_ff @(posedge clk) begin
		first_q <= first_n;
	end

	assign done  = done_q;
	assign count = count_q;

endmodule

[design/crlfrx_store.sv]
// Frame byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module crlfrx_store #(
	parameter int CAPACITY = 32
) (
	input  logic                           clk,
	input  crlfrx_pkg::wr_req_t            wr,
	input  logic                           rd_en,
	input  logic [crlfrx_pkg::INDEX_W-1:0] rd_index,
	output logic [7:0]                     rd_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [7:0]                     mem [CAPACITY];
	logic [7:0]                     rd_data_q;
	logic [crlfrx_pkg::COUNT_W-1:0] rd_index_ext;

	assign rd_index_ext = crlfrx_pkg::COUNT_W'(rd_index);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_index_ext[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/crlf_frame_receiver_top.sv]
// Top level of the CR LF frame receiver.
`timescale 1ns / 1ps

// Takes one beat per cycle while the input is not stalled: received bytes, status polls and store
// reads. Each beat passes an input register and then a result register, and a poll or read answer is
// presented from the result register; received bytes and operation code 3 give no result. The input
// stalls only while a result waits under a stalled output and the input register is occupied.
// The frame store is a register array with one write port at the current frame position and one
// registered read port. A poll of a complete frame reports it and clears it; the stored bytes
// stay readable. The start byte register may be written whenever the receiver is idle; its port
// is always ready.
module crlf_frame_receiver_top #(
	parameter int CAPACITY = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  crlfrx_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output crlfrx_pkg::out_item_t out_data
);

	localparam logic [crlfrx_pkg::COUNT_W-1:0] CAP = crlfrx_pkg::COUNT_W'(CAPACITY);

	logic                           valid_s1;
	crlfrx_pkg::in_item_t           item_s1;
	logic                           advance;
	logic                           fire;
	logic                           is_poll;
	logic                           is_read;
	logic                           rd_ok;
	logic [7:0]                     start_byte_q;
	logic                           out_valid_q;
	logic                           complete_q;
	logic [crlfrx_pkg::COUNT_W-1:0] length_q;
	logic                           rd_ok_q;
	crlfrx_pkg::wr_req_t            wr;
	logic                           done;
	logic [crlfrx_pkg::COUNT_W-1:0] count;
	logic [7:0]                     rd_data;

	assign cfg_ready = 1'b1;
	assign advance   = !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign fire      = valid_s1 && advance;
	assign is_poll   = item_s1.operation == crlfrx_pkg::OP_POLL;
	assign is_read   = item_s1.operation == crlfrx_pkg::OP_READ;
	assign rd_ok     = is_read && (crlfrx_pkg::COUNT_W'(item_s1.read_index) < CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'h00;
		end else if (cfg_valid) begin
			start_byte_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	crlfrx_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.start_byte(start_byte_q),
		.wr        (wr),
		.done      (done),
		.count     (count)
	);

	crlfrx_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (fire && rd_ok),
		.rd_index(item_s1.read_index),
		.rd_data (rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && (is_poll || is_read);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			complete_q <= is_poll && done;
			length_q   <= is_poll ? count : '0;
			rd_ok_q    <= rd_ok;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		out_data.frame_complete = complete_q;
		out_data.frame_length   = length_q;
		out_data.read_data      = rd_ok_q ? rd_data : 8'h00;
	end

endmodule
